// ===== rtl/core/tql_pkg.sv =====
// Shared types for the Q-learning agent step: configuration, commands and status.
package tql_pkg;

  // Index of an action inside a table row; at most sixteen actions.
  localparam int unsigned COL_W = 4;

  typedef enum logic [1:0] {
    SCAN_NONE = 2'd0,
    SCAN_QMAX = 2'd1,
    SCAN_VMIN = 2'd2,
    SCAN_PICK = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic       explore_mode;
    logic [8:0] learn_rate;
    logic [8:0] discount;
    logic [7:0] extreme_limit;
    logic [3:0] warmup_steps;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic             rd_prior;
    scan_mode_t       mode;
    logic [COL_W-1:0] col;
    logic             mul1;
    logic             mul2;
    logic             upd_wr;
    logic             div_init;
    logic             div_step;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic explore;
    logic upd_ok;
    logic force_act;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/core/tql_ctrl.sv =====
// Sequencer for the Q-learning agent step: row scans, update, tie selection and hand-off.
module tql_ctrl #(
  parameter int unsigned NUM_ACTIONS = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tql_pkg::status_t   sts,
  output tql_pkg::cmd_t      cmd
);

  localparam logic [4:0] NA_C     = 5'(NUM_ACTIONS);
  localparam logic [4:0] DIV_LAST = 5'd7;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_QSCAN = 10'b0000000010,
    S_URD   = 10'b0000000100,
    S_MUL1  = 10'b0000001000,
    S_MUL2  = 10'b0000010000,
    S_UWR   = 10'b0000100000,
    S_VSCAN = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_PICK  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.mode     = tql_pkg::SCAN_NONE;
    cmd.col      = cnt[tql_pkg::COL_W-1:0];
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_QSCAN;
        end
      end
      S_QSCAN: begin
        cmd.rd_en = (cnt < NA_C);
        cmd.mode  = tql_pkg::SCAN_QMAX;
        if (cnt == NA_C) begin
          cnt_next = '0;
          if (!sts.explore) begin
            state_next = S_DONE;
          end else if (sts.upd_ok) begin
            state_next = S_URD;
          end else if (!sts.force_act) begin
            state_next = S_VSCAN;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_URD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_prior = 1'b1;
        state_next   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_UWR;
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        cnt_next   = '0;
        state_next = sts.force_act ? S_DONE : S_VSCAN;
      end
      S_VSCAN: begin
        cmd.rd_en = (cnt < NA_C);
        cmd.mode  = tql_pkg::SCAN_VMIN;
        if (cnt == NA_C) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_PICK;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_PICK: begin
        cmd.rd_en = (cnt < NA_C);
        cmd.mode  = tql_pkg::SCAN_PICK;
        if (cnt == NA_C) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_commit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.out_busy)
    else $error("result committed while the output word is still held");
  a_upd_needs_permission: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_wr |-> (sts.explore && sts.upd_ok))
    else $error("table update without explore mode and warm-up passed");
  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("sequencer took a word but did not start work");
`endif

endmodule

// ===== rtl/core/tql_datapath.sv =====
// Datapath of the Q-learning agent step: tables, scans, update arithmetic and result register.
module tql_datapath #(
  parameter int unsigned NUM_ACTIONS = 9,
  parameter int unsigned VALUE_WIDTH = 20,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tql_pkg::cfg_t       cfg,
  input  tql_pkg::cmd_t       cmd,
  output tql_pkg::status_t    sts,
  input  logic signed [12:0]  in_angle,
  input  logic [7:0]          in_rnd,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [15:0]         out_data
);

  localparam int unsigned QW    = VALUE_WIDTH;
  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned DEPTH = 10 * NUM_ACTIONS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(NUM_ACTIONS + 1);
  localparam int unsigned PW    = QW + 10;
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned P3W   = SW + 10;
  localparam int unsigned ACW   = QW + 22;
  localparam int unsigned SHW   = ACW - 16;

  localparam logic [AW-1:0]         NA_A    = AW'(NUM_ACTIONS);
  localparam logic [3:0]            LAST_A  = 4'(NUM_ACTIONS - 1);
  localparam logic signed [QW-1:0]  Q_RESET = QW'(-32'sd25600);
  localparam logic signed [QW-1:0]  Q_MAX   = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0]  Q_MIN   = {1'b1, {(QW-1){1'b0}}};
  localparam logic [3:0]            ST_HI   = 4'd9;
  localparam logic [3:0]            ST_SAT  = 4'd15;

  function automatic logic [3:0] bin_angle(input logic signed [12:0] a);
    logic [3:0] s;
    if      (a < -13'sd320) s = 4'd9;
    else if (a < -13'sd240) s = 4'd8;
    else if (a < -13'sd160) s = 4'd7;
    else if (a < -13'sd80)  s = 4'd6;
    else if (a < 13'sd0)    s = 4'd5;
    else if (a < 13'sd80)   s = 4'd4;
    else if (a < 13'sd160)  s = 4'd3;
    else if (a < 13'sd240)  s = 4'd2;
    else if (a < 13'sd320)  s = 4'd1;
    else                    s = 4'd0;
    return s;
  endfunction

  // Step state
  logic [3:0]        cur;
  logic signed [4:0] reward;
  logic [7:0]        rnd;
  logic [3:0]        prior_state, prior_action;
  logic [7:0]        extreme_run, ext_next;
  logic [3:0]        step_total;
  logic              upd_ok, force_act;

  // Scan accumulators
  logic signed [QW-1:0] best;
  logic [3:0]           arg;
  logic [CW-1:0]        least;
  logic [NW-1:0]        tie_n, rem, match_n, match_cur;
  logic [7:0]           div_sh;
  logic [NW:0]          rem_w;
  logic [3:0]           pick;
  tql_pkg::scan_mode_t  acc_mode;
  logic [3:0]           acc_col;

  // Tables
  logic signed [QW-1:0] value_mem [DEPTH];
  logic [CW-1:0]        visit_mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic signed [QW-1:0] value_rd;
  logic [CW-1:0]        visit_rd;
  logic                 valid_rd;
  logic signed [QW-1:0] q_eff;
  logic [CW-1:0]        v_eff, v_inc;
  logic [AW-1:0]        prior_addr, row_addr, rd_addr;

  // Update arithmetic
  logic [8:0]             lc, dc, linv;
  logic signed [PW-1:0]   p1, p2;
  logic signed [SW-1:0]   r_term;
  logic signed [P3W-1:0]  p3;
  logic signed [ACW-1:0]  acc;
  logic signed [SHW-1:0]  sh;
  logic signed [QW-1:0]   q_new;
  logic [SHW-QW:0]        sh_top;

  logic signed [5:0]      rt;
  logic signed [4:0]      reward_c;
  logic [3:0]             cur_c;
  logic [3:0]             action_sel;

  assign cur_c    = bin_angle(in_angle);
  assign rt       = $signed({1'b0, cur_c, 1'b0}) - 6'sd9;
  assign reward_c = (rt < 6'sd0) ? rt[4:0] : 5'(-rt);

  assign ext_next  = (cur == 4'd0 || cur == ST_HI)
                     ? ((extreme_run == 8'hFF) ? extreme_run : extreme_run + 8'd1)
                     : 8'd0;
  assign upd_ok    = (extreme_run <= cfg.extreme_limit) && (step_total >= cfg.warmup_steps);
  assign force_act = (ext_next > cfg.extreme_limit);

  assign sts.explore   = cfg.explore_mode;
  assign sts.upd_ok    = upd_ok;
  assign sts.force_act = force_act;
  assign sts.out_busy  = out_valid && !out_ready;

  // Addressing: row-major, one row of actions per state
  assign prior_addr = AW'(prior_state) * NA_A + AW'(prior_action);
  assign row_addr   = AW'(cur) * NA_A + AW'(cmd.col);
  assign rd_addr    = cmd.rd_prior ? prior_addr : row_addr;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      value_rd <= value_mem[rd_addr];
      visit_rd <= visit_mem[rd_addr];
    end
    if (cmd.upd_wr) begin
      value_mem[prior_addr] <= q_new;
      visit_mem[prior_addr] <= v_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      valid_rd <= 1'b0;
    end else begin
      if (cmd.rd_en) valid_rd <= valid[rd_addr];
      if (cmd.upd_wr) valid[prior_addr] <= 1'b1;
    end
  end

  // Never-written entries read as their reset values
  assign q_eff = valid_rd ? value_rd : Q_RESET;
  assign v_eff = valid_rd ? visit_rd : '0;
  assign v_inc = (&v_eff) ? v_eff : v_eff + CW'(1);

  // Rates above one act as one
  assign lc   = (cfg.learn_rate > 9'd256) ? 9'd256 : cfg.learn_rate;
  assign dc   = (cfg.discount > 9'd256) ? 9'd256 : cfg.discount;
  assign linv = 9'd256 - lc;

  assign r_term = SW'(reward) <<< 15;
  assign acc    = (ACW'(p1) <<< 8) + ACW'(p3) + ACW'(32'sd32768);
  assign sh     = SHW'(acc >>> 16);
  assign sh_top = sh[SHW-1:QW-1];

  always_comb begin
    if ((&sh_top) || !(|sh_top)) begin
      q_new = sh[QW-1:0];
    end else if (sh[SHW-1]) begin
      q_new = Q_MIN;
    end else begin
      q_new = Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1 <= $signed({1'b0, linv}) * q_eff;
      p2 <= $signed({1'b0, dc}) * best;
    end
    if (cmd.mul2) begin
      p3 <= $signed({1'b0, lc}) * (r_term + SW'(p2));
    end
  end

  // Read data arrives in the cycle after the request; tag it with mode and column
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_mode <= tql_pkg::SCAN_NONE;
    end else begin
      acc_mode <= cmd.rd_en ? cmd.mode : tql_pkg::SCAN_NONE;
    end
    acc_col <= cmd.col;
  end

  assign match_cur = (acc_col == 4'd0) ? '0 : match_n;
  assign rem_w     = {rem, div_sh[7]};

  always_ff @(posedge clk) begin
    case (acc_mode)
      tql_pkg::SCAN_QMAX: begin
        if (acc_col == 4'd0 || q_eff > best) begin
          best <= q_eff;
          arg  <= acc_col;
        end
      end
      tql_pkg::SCAN_VMIN: begin
        if (acc_col == 4'd0 || v_eff < least) begin
          least <= v_eff;
          tie_n <= NW'(1);
        end else if (v_eff == least) begin
          tie_n <= tie_n + NW'(1);
        end
      end
      tql_pkg::SCAN_PICK: begin
        if (v_eff == least) begin
          if (match_cur == rem) pick <= acc_col;
          match_n <= match_cur + NW'(1);
        end else begin
          match_n <= match_cur;
        end
      end
      default: ;
    endcase

    // Restoring remainder of the random byte by the tie count, one bit a cycle
    if (cmd.div_init) begin
      rem    <= '0;
      div_sh <= rnd;
    end else if (cmd.div_step) begin
      if (rem_w >= {1'b0, tie_n}) begin
        rem <= NW'(rem_w - {1'b0, tie_n});
      end else begin
        rem <= rem_w[NW-1:0];
      end
      div_sh <= {div_sh[6:0], 1'b0};
    end
  end

  always_comb begin
    if (!cfg.explore_mode) begin
      action_sel = arg;
    end else if (force_act) begin
      action_sel = (cur == 4'd0) ? LAST_A : 4'd0;
    end else begin
      action_sel = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= cur_c;
      reward <= reward_c;
      rnd    <= in_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_state  <= 4'd4;
      prior_action <= 4'd0;
      extreme_run  <= 8'd0;
      step_total   <= 4'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        prior_state  <= cur;
        prior_action <= action_sel;
        if (step_total != ST_SAT) step_total <= step_total + 4'd1;
        if (cfg.explore_mode) extreme_run <= ext_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= {3'b000, reward, cur, action_sel};
    end
  end

`ifndef ASSERT_OFF
  a_commit_shows_word: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented on the output");
  a_tie_choice_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && cfg.explore_mode && !force_act) |-> (tie_n != '0) && (rem < tie_n))
    else $error("tie remainder outside the tie count");
  a_action_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (action_sel <= LAST_A))
    else $error("chosen action outside the action set");
  a_steps_counted: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (step_total != 4'd0))
    else $error("step count did not advance");
`endif

endmodule

// ===== rtl/core/tabular_q_learning_agent_step.sv =====
// Top level of the tabular Q-learning agent step: ports, configuration registers and wiring.
//
//   Channel  Direction  Handshake             Word contents
//   s_*      in         s_tvalid / s_tready   heading_angle, random_value
//   m_*      out        m_tvalid / m_tready   action_index, state_index, reward_half
//   cfg_*    in         cfg_valid / cfg_ready register index and write data
//
// In explore mode a word goes through a Q scan of its state's table row, the update (read,
// two multiplies and write) when it is allowed, a visit-count scan, the remainder unit and
// a pick scan; each pass over a row reads one entry a cycle through the single read port.
// Exploit mode makes only the Q scan; a forced correction makes the Q scan and, when it is
// allowed, the update. The next word is taken in the cycle after a result is committed.
// Reset is synchronous, sets the sequencer, step state and configuration registers to their
// defaults and clears the table valid bits, so every entry reads as its reset value at once
// with no clearing pass. A finished word waits in the output register while the next input
// is accepted and worked on; only the hand-over of the next result waits for m_tready.
module tabular_q_learning_agent_step #(
  parameter int unsigned NUM_ACTIONS = 9,
  parameter int unsigned VALUE_WIDTH = 20,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [12:0] heading_angle, [20:13] random_value, rest zero
  // Result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] action_index, [7:4] state_index, [12:8] reward_half
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam logic [2:0] REG_EXPLORE  = 3'd0;
  localparam logic [2:0] REG_LEARN    = 3'd1;
  localparam logic [2:0] REG_DISCOUNT = 3'd2;
  localparam logic [2:0] REG_LIMIT    = 3'd3;
  localparam logic [2:0] REG_WARMUP   = 3'd4;

  tql_pkg::cfg_t    cfg;
  tql_pkg::cmd_t    cmd;
  tql_pkg::status_t sts;

  // Configuration is always accepted; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.explore_mode  <= 1'b1;
      cfg.learn_rate    <= 9'd64;
      cfg.discount      <= 9'd0;
      cfg.extreme_limit <= 8'd2;
      cfg.warmup_steps  <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPLORE:  cfg.explore_mode  <= cfg_data[0];
        REG_LEARN:    cfg.learn_rate    <= cfg_data;
        REG_DISCOUNT: cfg.discount      <= cfg_data;
        REG_LIMIT:    cfg.extreme_limit <= cfg_data[7:0];
        REG_WARMUP:   cfg.warmup_steps  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // The sequencer steps through the scans and the update; it sees only the input handshake and the status.
  tql_ctrl #(
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds both tables, the step state and the result register.
  tql_datapath #(
    .NUM_ACTIONS (NUM_ACTIONS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_angle  ($signed(s_tdata[12:0])),
    .in_rnd    (s_tdata[20:13]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
